// ----- src/assert_macros.svh -----
// assertion macros used by the sequencer (salc_ctrl) of the cache tag store
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- src/salc_pkg.sv -----
// shared types, codes and helpers of the cache tag store
// no dependencies
package salc_pkg;

    localparam logic [1:0] OUTCOME_HIT        = 2'd0;
    localparam logic [1:0] OUTCOME_CLEAN_MISS = 2'd1;
    localparam logic [1:0] OUTCOME_DIRTY_MISS = 2'd2;

    localparam logic [1:0] CFG_BLOCK_OFFSET = 2'd0;
    localparam logic [1:0] CFG_SET_BITS     = 2'd1;
    localparam logic [1:0] CFG_WAYS         = 2'd2;
    localparam logic [1:0] CFG_PENALTY      = 2'd3;

    localparam int CFG_DATA_W  = 10;
    localparam int OFFSET_MAX  = 16;
    localparam int TAG_W       = 32;
    localparam int OP_W        = 32;
    localparam int META_W      = OP_W + 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 192;

    // floor of log2, at least 0
    function automatic int floor_log2(input int value);
        int k;
        k = 0;
        while ((64'd1 << (k + 1)) <= 64'(value))
            k++;
        return k;
    endfunction

    typedef struct packed {
        logic clear;    // write one zero row of the metadata store
        logic lookup;   // capture the accepted transaction and read its set
        logic commit;   // update the set and load the result register
    } cmd_t;

    typedef struct packed {
        logic clr_done; // clearing pointer at the last row
        logic out_full; // result register holds an untaken transaction
    } sts_t;

endpackage

// ----- src/salc_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ----- src/salc_ctrl.sv -----
// sequencer of the cache tag store: clearing pass, accept, lookup and commit
// depends on salc_pkg and assert_macros.svh
`include "assert_macros.svh"

module salc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          m_tready,
    input  salc_pkg::sts_t sts,
    output salc_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_free;

    assign out_free = !sts.out_full || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.lookup = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_accept_to_look, clk, rst_n, s_tvalid && s_tready, state_reg == ST_LOOK)
    `ASSERT_IMPL(a_commit_slot_free, clk, rst_n, cmd.commit, !sts.out_full || m_tready)
    `ASSERT_NEXT(a_clear_ends, clk, rst_n, state_reg == ST_CLEAR && sts.clr_done, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_no_clear_and_lookup, clk, rst_n, cmd.clear, !cmd.lookup && !cmd.commit)

endmodule

// ----- src/salc_dp.sv -----
// datapath of the cache tag store: config registers, set stores, way choice, result
// depends on salc_pkg and salc_ram
module salc_dp #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_addr,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [salc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [salc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  salc_pkg::cmd_t                      cmd,
    output salc_pkg::sts_t                      sts
);

    localparam int SMAX   = salc_pkg::floor_log2(MAX_SETS);
    localparam int DEPTH  = 1 << SMAX;
    localparam int AW     = (SMAX < 1) ? 1 : SMAX;
    localparam int RDEPTH = (DEPTH < 2) ? 2 : DEPTH;
    localparam int MW     = salc_pkg::META_W;
    localparam int TW     = salc_pkg::TAG_W;

    logic [4:0] bob_reg;
    logic [3:0] sib_reg;
    logic [3:0] ways_reg;
    logic [9:0] pen_reg;

    logic [AW-1:0] clr_reg;
    logic [31:0]   op_reg;
    logic          kind_reg;
    logic [31:0]   tag_reg;
    logic [AW-1:0] set_reg;
    logic          out_valid_reg;
    logic [salc_pkg::OUT_TDATA_W-1:0] out_reg;

    logic [4:0]  bob;
    logic [4:0]  sib;
    logic [4:0]  ways;
    logic [31:0] in_addr;
    logic [31:0] set_mask;
    logic [31:0] acc_set;
    logic [31:0] acc_tag;

    logic [MAX_WAYS*MW-1:0] meta_rd, meta_wr, meta_wdata;
    logic [MAX_WAYS*TW-1:0] tag_rd, tag_wr;
    logic [AW-1:0]          meta_waddr;

    // effective field widths and way count after clamping
    always_comb
    begin
        bob = (bob_reg > 5'(salc_pkg::OFFSET_MAX)) ? 5'(salc_pkg::OFFSET_MAX) : bob_reg;
        sib = ({1'b0, sib_reg} > 5'(SMAX)) ? 5'(SMAX) : {1'b0, sib_reg};
        if (ways_reg == 4'd0)
        begin
            ways = 5'd1;
        end
        else if ({1'b0, ways_reg} > 5'(MAX_WAYS))
        begin
            ways = 5'(MAX_WAYS);
        end
        else
        begin
            ways = {1'b0, ways_reg};
        end
    end

    assign in_addr  = s_tdata[32:1];
    assign set_mask = (32'd1 << sib) - 32'd1;
    assign acc_set  = (in_addr >> bob) & set_mask;
    assign acc_tag  = in_addr >> (bob + sib);

    // way choice over the registered set
    logic                hit, found_empty, have_lru;
    logic [3:0]          hit_way, empty_way, lru_way, way;
    logic [31:0]         min_stamp;
    logic                pv, pd;
    logic [31:0]         pt, plu;

    always_comb
    begin
        hit = 1'b0;
        found_empty = 1'b0;
        have_lru = 1'b0;
        hit_way = '0;
        empty_way = '0;
        lru_way = '0;
        min_stamp = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (5'(w) < ways && !hit)
            begin
                if (meta_rd[w*MW+MW-1] && tag_rd[w*TW +: TW] == tag_reg)
                begin
                    hit = 1'b1;
                    hit_way = 4'(w);
                end
                else if (!meta_rd[w*MW+MW-1])
                begin
                    if (!found_empty)
                    begin
                        found_empty = 1'b1;
                        empty_way = 4'(w);
                    end
                end
                else if (!have_lru || (meta_rd[w*MW +: 32] + 32'd1) < min_stamp)
                begin
                    // stamp of a touched line is its last op index plus one
                    have_lru = 1'b1;
                    min_stamp = meta_rd[w*MW +: 32] + 32'd1;
                    lru_way = 4'(w);
                end
            end
        end
        way = hit ? hit_way : (found_empty ? empty_way : lru_way);
        pv  = 1'b0;
        pd  = 1'b0;
        pt  = '0;
        plu = '0;
        meta_wr = meta_rd;
        tag_wr  = tag_rd;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (4'(w) == way)
            begin
                pv  = meta_rd[w*MW+MW-1];
                pd  = meta_rd[w*MW+MW-2];
                plu = meta_rd[w*MW +: 32];
                pt  = pv ? tag_rd[w*TW +: TW] : 32'd0;
                meta_wr[w*MW +: MW] = {1'b1, (hit && pd) || kind_reg, op_reg};
                tag_wr[w*TW +: TW]  = tag_reg;
            end
        end
    end

    logic [1:0]  outcome;
    logic [10:0] atime;
    logic [16:0] block, fetched, evicted;

    always_comb
    begin
        block = 17'd1 << bob;
        if (hit)
        begin
            outcome = salc_pkg::OUTCOME_HIT;
            atime   = 11'd1;
            fetched = '0;
            evicted = '0;
        end
        else if (pv && pd)
        begin
            outcome = salc_pkg::OUTCOME_DIRTY_MISS;
            atime   = 11'd1 + {pen_reg, 1'b0};
            fetched = block;
            evicted = block;
        end
        else
        begin
            outcome = salc_pkg::OUTCOME_CLEAN_MISS;
            atime   = 11'd1 + {1'b0, pen_reg};
            fetched = block;
            evicted = '0;
        end
    end

    assign meta_waddr = cmd.clear ? clr_reg : set_reg;
    assign meta_wdata = cmd.clear ? '0 : meta_wr;

    salc_ram #(.WIDTH(MAX_WAYS*MW), .DEPTH(RDEPTH)) u_meta_ram (
        .clk   (clk),
        .we    (cmd.clear || cmd.commit),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (cmd.lookup),
        .raddr (acc_set[AW-1:0]),
        .rdata (meta_rd)
    );

    salc_ram #(.WIDTH(MAX_WAYS*TW), .DEPTH(RDEPTH)) u_tag_ram (
        .clk   (clk),
        .we    (cmd.commit),
        .waddr (set_reg),
        .wdata (tag_wr),
        .re    (cmd.lookup),
        .raddr (acc_set[AW-1:0]),
        .rdata (tag_rd)
    );

    assign sts.clr_done = (clr_reg == AW'(DEPTH - 1));
    assign sts.out_full = out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bob_reg       <= 5'd6;
            sib_reg       <= 4'd6;
            ways_reg      <= 4'd1;
            pen_reg       <= 10'd100;
            clr_reg       <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    salc_pkg::CFG_BLOCK_OFFSET: bob_reg  <= cfg_data[4:0];
                    salc_pkg::CFG_SET_BITS:     sib_reg  <= cfg_data[3:0];
                    salc_pkg::CFG_WAYS:         ways_reg <= cfg_data[3:0];
                    salc_pkg::CFG_PENALTY:      pen_reg  <= cfg_data[9:0];
                    default:                    ;
                endcase
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.commit)
            begin
                op_reg        <= op_reg + 32'd1;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            kind_reg <= s_tdata[0];
            tag_reg  <= acc_tag;
            set_reg  <= acc_set[AW-1:0];
        end
        if (cmd.commit)
        begin
            out_reg <= {2'b00, evicted, fetched, atime, plu, pd, pt, pv,
                        3'(way), tag_reg, 10'(set_reg), outcome, op_reg};
        end
    end

endmodule

// ----- src/set_assoc_lru_cache_access_top.sv -----
// top level of the set-associative write-back lru cache tag store
// depends on salc_pkg, salc_ctrl, salc_dp (and through it salc_ram)

// Each accepted transaction is one cache access; it yields one result transaction.
// An access reads the whole set (all ways, tag and metadata rams) in a lookup step;
// a commit step then compares all ways in parallel, writes the set back and
// loads the result register. A new access is accepted as soon as the
// previous one has committed, even while its result still waits on m_tready;
// a commit waits only when the result register is still full. After reset a
// clearing pass zeroes all 2**floor(log2 MAX_SETS) sets of the metadata
// store (1024 by default), one set per cycle, before the first access is accepted;
// configuration writes are taken at any time. Registers: 0 block offset bits,
// 1 set index bits, 2 ways in use, 3 memory penalty; other indexes are ignored.
module set_assoc_lru_cache_access_top #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [9:0]   cfg_data,
    // access transactions
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // kind[0], address[32:1], zero fill
    // result transactions
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata    // op_index, outcome, set_index, tag_value, way_used,
                                    // old_valid, old_tag, old_dirty, old_last_used,
                                    // access_time, bytes_fetched, bytes_evicted, zero fill
);

    salc_pkg::cmd_t cmd;
    salc_pkg::sts_t sts;

    // sequencer
    salc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // set stores, way choice and result register
    salc_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
